@@ src/assert_macros.svh @@
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Value must stay unchanged in the cycle after the trigger.
`define ASSERT_HOLD(label, trig, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ src/caup_pkg.sv @@
// Package for the clause store: codes, state encoding, control structs.
`default_nettype none
package caup_pkg;

	localparam int LIT_W = 9;
	localparam int TGT_W = 10;
	localparam int VAL_W = 2;
	localparam int ACT_W = 7;

	localparam logic [VAL_W-1:0] VAL_UNSET = 2'd0;
	localparam logic [VAL_W-1:0] VAL_FALSE = 2'd1;
	localparam logic [VAL_W-1:0] VAL_TRUE  = 2'd2;

	typedef enum logic [2:0] {
		MODE_APPEND = 3'd0,
		MODE_CLOSE  = 3'd1,
		MODE_ASSIGN = 3'd2,
		MODE_CHECK  = 3'd3,
		MODE_PROP   = 3'd4,
		MODE_CLEAR  = 3'd5,
		MODE_READ   = 3'd6,
		MODE_NOP    = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		PASS_ASSIGN,
		PASS_CHECK,
		PASS_FIND,
		PASS_CONFL,
		PASS_APPLY
	} pass_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_ONE,
		S_FIND,
		S_CONFL,
		S_APPLY,
		S_CLR,
		S_VWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic  load;
		logic  append;
		logic  close;
		logic  clear;
		logic  sweep;
		logic  pass_start;
		pass_t kind;
		logic  var_capture;
		logic  record;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  lit_zero;
		logic  pass_idle;
		logic  found;
		logic  conflict;
		logic  sweep_last;
		logic  out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ src/caup_dp.sv @@
// Datapath: clause row memory, open clause buffer, row scan, variable memory, result register.
`default_nettype none
module caup_dp #(
	parameter int MAX_CLAUSES         = 64,
	parameter int MAX_LITS_PER_CLAUSE = 8,
	parameter int MAX_VARS            = 255
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire caup_pkg::cmd_t                  cmd,
	output caup_pkg::sts_t                       sts,
	input  wire logic [2:0]                      mode,
	input  wire logic signed [caup_pkg::LIT_W-1:0] literal,
	input  wire logic                            polarity,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 ok,
	output logic                                 formula_empty,
	output logic [caup_pkg::ACT_W-1:0]           active_clauses,
	output logic                                 overflow,
	output logic [caup_pkg::VAL_W-1:0]           var_value
);

	localparam int L   = MAX_LITS_PER_CLAUSE;
	localparam int LW  = $clog2(L);
	localparam int FW  = $clog2(L + 1);
	localparam int CW  = $clog2(MAX_CLAUSES);
	localparam int CNW = $clog2(MAX_CLAUSES + 1);
	localparam int VW  = $clog2(MAX_VARS);
	localparam int LB  = L * caup_pkg::LIT_W;
	localparam int RW  = LB + L + 1;

	// latched item
	caup_pkg::mode_t                    mode_q;
	logic signed [caup_pkg::LIT_W-1:0]  lit_q;
	logic                               pol_q;

	// store bookkeeping
	logic [CNW-1:0]                     next_slot_q;
	logic [FW-1:0]                      fill_q;
	logic [CNW-1:0]                     active_q;
	logic [caup_pkg::LIT_W-1:0]         open_q [L];

	// row memory and scan
	logic [RW-1:0]                      row_mem [MAX_CLAUSES];
	logic [RW-1:0]                      rd_row_q;
	logic [CNW-1:0]                     iss_q;
	logic                               iss_on_q;
	logic                               s1_valid_q;
	logic [CW-1:0]                      row_s1;
	caup_pkg::pass_t                    kind_q;
	logic signed [caup_pkg::TGT_W-1:0]  tgt_q;
	logic signed [caup_pkg::LIT_W-1:0]  pick_q;
	logic                               found_q;
	logic                               conflict_q;
	logic                               ovf_q;
	logic [caup_pkg::VAL_W-1:0]         val_q;

	// variable memory
	logic [caup_pkg::VAL_W-1:0]         var_mem [MAX_VARS];
	logic [caup_pkg::VAL_W-1:0]         var_rd_q;
	logic [VW-1:0]                      sweep_q;

	// result register
	logic                               out_valid_q;
	logic                               out_ok_q;
	logic                               out_empty_q;
	logic [caup_pkg::ACT_W-1:0]         out_act_q;
	logic                               out_ovf_q;
	logic [caup_pkg::VAL_W-1:0]         out_val_q;

	// combinational
	logic signed [caup_pkg::TGT_W-1:0]  lit10;
	logic signed [caup_pkg::TGT_W-1:0]  chosen;
	logic signed [caup_pkg::TGT_W-1:0]  neg;
	logic signed [caup_pkg::LIT_W-1:0]  rlit [L];
	logic [L-1:0]                       rmask;
	logic                               ract;
	logic [caup_pkg::LIT_W-1:0]         only;
	logic                               unit;
	logic                               confl_hit;
	logic                               hitpos;
	logic [L-1:0]                       strikes;
	logic                               abort;
	logic                               row_we;
	logic [CW-1:0]                      row_wa;
	logic [RW-1:0]                      row_wd;
	logic [L-1:0]                       close_mask;
	logic [LB-1:0]                      open_flat;
	logic                               wb;
	logic                               dec;
	logic                               last_issue;
	logic                               store_full;
	logic [caup_pkg::LIT_W-1:0]         item_mag;
	logic [caup_pkg::LIT_W-1:0]         pick_mag;
	logic [16:0]                        item_m1;
	logic [16:0]                        pick_m1;
	logic                               item_in_range;
	logic                               pick_in_range;
	logic                               var_we;
	logic [VW-1:0]                      var_wa;
	logic [caup_pkg::VAL_W-1:0]         var_wd;

	assign lit10  = {lit_q[caup_pkg::LIT_W-1], lit_q};
	assign chosen = pol_q ? lit10 : -lit10;
	assign neg    = -tgt_q;

	// row unpack and per-row evaluation
	always_comb begin
		only    = '0;
		hitpos  = 1'b0;
		strikes = '0;
		for (int j = 0; j < L; j++) begin
			rlit[j]  = rd_row_q[j*caup_pkg::LIT_W +: caup_pkg::LIT_W];
			rmask[j] = rd_row_q[LB + j];
		end
		ract = rd_row_q[RW-1];
		for (int j = 0; j < L; j++) begin
			if (rmask[j]) begin
				only = only | rlit[j];
				if ({rlit[j][caup_pkg::LIT_W-1], rlit[j]} == tgt_q) begin
					hitpos = 1'b1;
				end
				if ({rlit[j][caup_pkg::LIT_W-1], rlit[j]} == neg) begin
					strikes[j] = 1'b1;
				end
			end
		end
		unit      = ract && $onehot(rmask);
		confl_hit = unit && ({only[caup_pkg::LIT_W-1], only} == neg);
	end

	always_comb begin
		abort = 1'b0;
		wb    = 1'b0;
		if (s1_valid_q) begin
			case (kind_q)
				caup_pkg::PASS_CHECK, caup_pkg::PASS_CONFL: begin
					abort = confl_hit;
				end
				caup_pkg::PASS_ASSIGN: begin
					abort = confl_hit;
					wb    = ract && !confl_hit;
				end
				caup_pkg::PASS_APPLY: begin
					wb = ract;
				end
				default: begin
				end
			endcase
		end
		dec = wb && hitpos;
	end

	always_comb begin
		for (int j = 0; j < L; j++) begin
			close_mask[j] = FW'(j) < fill_q;
			open_flat[j*caup_pkg::LIT_W +: caup_pkg::LIT_W] = open_q[j];
		end
	end

	assign store_full = next_slot_q == CNW'(MAX_CLAUSES);
	assign last_issue = CNW'(iss_q + CNW'(1)) == next_slot_q;

	always_comb begin
		row_we = 1'b0;
		row_wa = row_s1;
		row_wd = {~hitpos, (hitpos ? rmask : (rmask & ~strikes)), rd_row_q[LB-1:0]};
		if (cmd.close && !store_full) begin
			row_we = 1'b1;
			row_wa = next_slot_q[CW-1:0];
			row_wd = {1'b1, close_mask, open_flat};
		end else if (wb) begin
			row_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wa] <= row_wd;
		end
		rd_row_q <= row_mem[iss_q[CW-1:0]];
	end

	// open clause literals
	always_ff @(posedge clk) begin
		if (cmd.append && lit_q != '0 && !store_full && fill_q != FW'(L)) begin
			open_q[fill_q[LW-1:0]] <= lit_q;
		end
	end

	// variable index math
	assign item_mag      = lit_q[caup_pkg::LIT_W-1] ? caup_pkg::LIT_W'(-lit_q) : lit_q;
	assign pick_mag      = pick_q[caup_pkg::LIT_W-1] ? caup_pkg::LIT_W'(-pick_q) : pick_q;
	assign item_m1       = {8'd0, item_mag} - 17'd1;
	assign pick_m1       = {8'd0, pick_mag} - 17'd1;
	assign item_in_range = item_mag != '0 && 32'(item_mag) <= 32'(MAX_VARS);
	assign pick_in_range = pick_mag != '0 && 32'(pick_mag) <= 32'(MAX_VARS);

	always_comb begin
		var_we = 1'b0;
		var_wa = sweep_q;
		var_wd = caup_pkg::VAL_UNSET;
		if (cmd.sweep) begin
			var_we = 1'b1;
		end else if (cmd.record && pick_in_range) begin
			var_we = 1'b1;
			var_wa = pick_m1[VW-1:0];
			var_wd = pick_q[caup_pkg::LIT_W-1] ? caup_pkg::VAL_FALSE : caup_pkg::VAL_TRUE;
		end
	end

	always_ff @(posedge clk) begin
		if (var_we) begin
			var_mem[var_wa] <= var_wd;
		end
		var_rd_q <= var_mem[item_m1[VW-1:0]];
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= caup_pkg::mode_t'(mode);
			lit_q  <= literal;
			pol_q  <= polarity;
		end
		if (cmd.pass_start) begin
			kind_q <= cmd.kind;
			if (cmd.kind == caup_pkg::PASS_CONFL || cmd.kind == caup_pkg::PASS_APPLY) begin
				tgt_q <= {pick_q[caup_pkg::LIT_W-1], pick_q};
			end else begin
				tgt_q <= chosen;
			end
		end
		if (s1_valid_q && kind_q == caup_pkg::PASS_FIND && unit) begin
			pick_q <= only;
		end
		if (cmd.emit) begin
			out_ok_q    <= ~conflict_q;
			out_empty_q <= active_q == '0;
			out_act_q   <= (32'(active_q) > 32'd127) ? caup_pkg::ACT_W'(127)
				: caup_pkg::ACT_W'(active_q);
			out_ovf_q   <= ovf_q;
			out_val_q   <= val_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot_q <= '0;
			fill_q      <= '0;
			active_q    <= '0;
			iss_q       <= '0;
			iss_on_q    <= 1'b0;
			s1_valid_q  <= 1'b0;
			row_s1      <= '0;
			found_q     <= 1'b0;
			conflict_q  <= 1'b0;
			ovf_q       <= 1'b0;
			val_q       <= caup_pkg::VAL_UNSET;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				conflict_q <= 1'b0;
				ovf_q      <= 1'b0;
				val_q      <= caup_pkg::VAL_UNSET;
			end
			if (cmd.append && lit_q != '0) begin
				if (store_full || fill_q == FW'(L)) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= FW'(fill_q + FW'(1));
				end
			end
			if (cmd.close) begin
				if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					next_slot_q <= CNW'(next_slot_q + CNW'(1));
					fill_q      <= '0;
				end
			end
			if (cmd.close && !store_full) begin
				active_q <= CNW'(active_q + CNW'(1));
			end else if (dec) begin
				active_q <= CNW'(active_q - CNW'(1));
			end
			if (cmd.clear) begin
				next_slot_q <= '0;
				fill_q      <= '0;
				active_q    <= '0;
			end
			if (cmd.sweep) begin
				sweep_q <= (sweep_q == VW'(MAX_VARS - 1)) ? '0 : VW'(sweep_q + VW'(1));
			end
			if (cmd.var_capture) begin
				val_q <= item_in_range ? var_rd_q : caup_pkg::VAL_UNSET;
			end

			// row scan: issue a row read, then evaluate the registered row in the next cycle
			if (cmd.pass_start) begin
				iss_q      <= '0;
				iss_on_q   <= next_slot_q != '0;
				s1_valid_q <= 1'b0;
				found_q    <= 1'b0;
				conflict_q <= 1'b0;
			end else begin
				s1_valid_q <= iss_on_q && !abort;
				row_s1     <= iss_q[CW-1:0];
				if (iss_on_q) begin
					iss_q    <= CNW'(iss_q + CNW'(1));
					iss_on_q <= !last_issue && !abort;
				end
				if (abort) begin
					conflict_q <= 1'b1;
				end
				if (s1_valid_q && kind_q == caup_pkg::PASS_FIND && unit) begin
					found_q <= 1'b1;
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.mode       = mode_q;
		sts.lit_zero   = lit_q == '0;
		sts.pass_idle  = !iss_on_q && !s1_valid_q;
		sts.found      = found_q;
		sts.conflict   = conflict_q;
		sts.sweep_last = sweep_q == VW'(MAX_VARS - 1);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid      = out_valid_q;
	assign ok             = out_ok_q;
	assign formula_empty  = out_empty_q;
	assign active_clauses = out_act_q;
	assign overflow       = out_ovf_q;
	assign var_value      = out_val_q;

endmodule
`default_nettype wire

@@ src/caup_ctrl.sv @@
// Controller: sequences item execution, row scan passes and the variable clear sweep.
`default_nettype none
module caup_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire caup_pkg::sts_t  sts,
	output caup_pkg::cmd_t       cmd
);

	caup_pkg::state_t state_q;
	caup_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= caup_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			caup_pkg::S_INIT: begin
				if (sts.sweep_last) state_d = caup_pkg::S_IDLE;
			end
			caup_pkg::S_IDLE: begin
				if (in_valid) state_d = caup_pkg::S_EXEC;
			end
			caup_pkg::S_EXEC: begin
				case (sts.mode)
					caup_pkg::MODE_ASSIGN, caup_pkg::MODE_CHECK: begin
						state_d = sts.lit_zero ? caup_pkg::S_DONE : caup_pkg::S_ONE;
					end
					caup_pkg::MODE_PROP:  state_d = caup_pkg::S_FIND;
					caup_pkg::MODE_CLEAR: state_d = caup_pkg::S_CLR;
					caup_pkg::MODE_READ:  state_d = caup_pkg::S_VWAIT;
					default:              state_d = caup_pkg::S_DONE;
				endcase
			end
			caup_pkg::S_ONE: begin
				if (sts.pass_idle) state_d = caup_pkg::S_DONE;
			end
			caup_pkg::S_FIND: begin
				if (sts.pass_idle) begin
					state_d = sts.found ? caup_pkg::S_CONFL : caup_pkg::S_DONE;
				end
			end
			caup_pkg::S_CONFL: begin
				if (sts.pass_idle) begin
					state_d = sts.conflict ? caup_pkg::S_DONE : caup_pkg::S_APPLY;
				end
			end
			caup_pkg::S_APPLY: begin
				if (sts.pass_idle) state_d = caup_pkg::S_FIND;
			end
			caup_pkg::S_CLR: begin
				if (sts.sweep_last) state_d = caup_pkg::S_DONE;
			end
			caup_pkg::S_VWAIT: begin
				state_d = caup_pkg::S_DONE;
			end
			caup_pkg::S_DONE: begin
				if (sts.out_free) state_d = caup_pkg::S_IDLE;
			end
			default: begin
				state_d = caup_pkg::S_INIT;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.kind = caup_pkg::PASS_ASSIGN;
		in_stall = state_q != caup_pkg::S_IDLE;
		case (state_q)
			caup_pkg::S_INIT: begin
				cmd.sweep = 1'b1;
			end
			caup_pkg::S_IDLE: begin
				cmd.load = in_valid;
			end
			caup_pkg::S_EXEC: begin
				case (sts.mode)
					caup_pkg::MODE_APPEND: cmd.append = 1'b1;
					caup_pkg::MODE_CLOSE:  cmd.close  = 1'b1;
					caup_pkg::MODE_ASSIGN: begin
						cmd.pass_start = !sts.lit_zero;
						cmd.kind       = caup_pkg::PASS_ASSIGN;
					end
					caup_pkg::MODE_CHECK: begin
						cmd.pass_start = !sts.lit_zero;
						cmd.kind       = caup_pkg::PASS_CHECK;
					end
					caup_pkg::MODE_PROP: begin
						cmd.pass_start = 1'b1;
						cmd.kind       = caup_pkg::PASS_FIND;
					end
					caup_pkg::MODE_CLEAR: cmd.clear = 1'b1;
					default: begin
					end
				endcase
			end
			caup_pkg::S_FIND: begin
				if (sts.pass_idle && sts.found) begin
					cmd.pass_start = 1'b1;
					cmd.kind       = caup_pkg::PASS_CONFL;
				end
			end
			caup_pkg::S_CONFL: begin
				if (sts.pass_idle && !sts.conflict) begin
					cmd.pass_start = 1'b1;
					cmd.kind       = caup_pkg::PASS_APPLY;
				end
			end
			caup_pkg::S_APPLY: begin
				if (sts.pass_idle) begin
					cmd.record     = 1'b1;
					cmd.pass_start = 1'b1;
					cmd.kind       = caup_pkg::PASS_FIND;
				end
			end
			caup_pkg::S_CLR: begin
				cmd.sweep = 1'b1;
			end
			caup_pkg::S_VWAIT: begin
				cmd.var_capture = 1'b1;
			end
			caup_pkg::S_DONE: begin
				cmd.emit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/clause_assign_unit_propagate.sv @@
// Top level of the bounded clause store with assignment and unit propagation.
// One item at a time: an item is taken only while the block is idle, and its single
// result goes to an output register; a waiting result holds back only the next result.
// Steps per item, with N the number of slots used since the last clear (at most
// MAX_CLAUSES) and one row read per cycle from the clause row memory:
//   append, close, no-op: execute, then hand off; read variable: read, capture, hand off;
//   assign and check: one row pass if N is above zero, ending early on a conflict;
//   propagate: find, conflict and apply passes per unit clause taken, plus one final find pass;
//   clear: the sweep that zeroes all MAX_VARS entries of the variable memory.
// After reset the same sweep zeroes the variable memory with in_stall high.
// Clause slots are filled in order and a deleted slot is only marked inactive, so the
// scan order is always slot order. A clause struck down to no literals stays active.
`default_nettype none
module clause_assign_unit_propagate #(
	parameter int MAX_CLAUSES         = 64,
	parameter int MAX_LITS_PER_CLAUSE = 8,
	parameter int MAX_VARS            = 255
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [2:0]                          mode,
	input  wire logic signed [caup_pkg::LIT_W-1:0]   literal,
	input  wire logic                                polarity,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     ok,
	output logic                                     formula_empty,
	output logic [caup_pkg::ACT_W-1:0]               active_clauses,
	output logic                                     overflow,
	output logic [caup_pkg::VAL_W-1:0]               var_value
);

	caup_pkg::cmd_t cmd;
	caup_pkg::sts_t sts;

	// sequencer: item decode, pass order, clear sweep, result hand-off
	caup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and per-row evaluation
	caup_dp #(
		.MAX_CLAUSES         (MAX_CLAUSES),
		.MAX_LITS_PER_CLAUSE (MAX_LITS_PER_CLAUSE),
		.MAX_VARS            (MAX_VARS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.literal        (literal),
		.polarity       (polarity),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.ok             (ok),
		.formula_empty  (formula_empty),
		.active_clauses (active_clauses),
		.overflow       (overflow),
		.var_value      (var_value)
	);

endmodule
`default_nettype wire

@@ src/caup_checker.sv @@
// Port-level checker for the clause store, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module caup_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        ok,
	input wire logic                        formula_empty,
	input wire logic [caup_pkg::ACT_W-1:0]  active_clauses,
	input wire logic                        overflow,
	input wire logic [caup_pkg::VAL_W-1:0]  var_value
);

	`ASSERT_ALWAYS(a_empty_match, !out_valid || (formula_empty == (active_clauses == '0)), "formula_empty disagrees with active count")
	`ASSERT_ALWAYS(a_ovf_no_confl, !out_valid || !overflow || ok, "overflow item reported a conflict")
	`ASSERT_ALWAYS(a_val_only_read, !out_valid || var_value == caup_pkg::VAL_UNSET || (ok && !overflow), "variable value on a failing item")
	`ASSERT_HOLD(a_out_hold, out_valid && out_stall, {out_valid, ok, formula_empty, active_clauses, overflow, var_value}, "stalled result changed")

endmodule

bind clause_assign_unit_propagate caup_checker u_caup_checker (.*);
`default_nettype wire
